FILE: rtl/core/tga_rle_pixel_packet_encoder_top_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef TGA_RLE_PIXEL_PACKET_ENCODER_TOP_DEFINES_SVH
`define TGA_RLE_PIXEL_PACKET_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTH
`define TGA_RLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
`define TGA_RLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`else
`define TGA_RLE_ASSERT(lbl, clk, rstn, prop, msg)
`define TGA_RLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/core/tga_rle_pkg.sv
package tga_rle_pkg;

  localparam int MaxPacket  = 128;
  localparam int WordsOut   = 4;
  localparam int QueueDepth = 4;

  localparam logic [7:0] RepeatFlag = 8'h80;
  localparam logic [7:0] LenMask    = 8'h7F;

  localparam logic [1:0] FMT_ONE_BYTE   = 2'd0;
  localparam logic [1:0] FMT_THREE_BYTE = 2'd1;
  localparam logic [1:0] FMT_FOUR_BYTE  = 2'd2;

  localparam logic PLAIN_MODE  = 1'b0;
  localparam logic PACKET_MODE = 1'b1;

  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_RLE_ENABLE   = 1'b1;

  typedef enum logic [1:0] {
    RUN_EMPTY,
    RUN_ONE,
    RUN_REPEAT,
    RUN_RAW
  } run_mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_OUT
  } back_state_t;

  typedef enum logic {
    CMD_PIXEL,
    CMD_STORE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        bank;
    logic [7:0]  len;
    logic        has_hdr;
    logic [7:0]  hdr;
    logic        pkt_end;
    logic        img_end;
    logic [31:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [31:0] fmt_mask(logic [1:0] fmt);
    logic [31:0] m;
    unique case (fmt)
      FMT_ONE_BYTE:   m = 32'h0000_00FF;
      FMT_THREE_BYTE: m = 32'h00FF_FFFF;
      default:        m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic cmd_t plain_cmd(logic [31:0] pixel);
    cmd_t c;
    c = '0;
    c.kind  = CMD_PIXEL;
    c.pixel = pixel;
    return c;
  endfunction

  function automatic cmd_t flush_cmd(run_mode_t mode, logic [7:0] len, logic [31:0] prior,
                                     logic [31:0] head, logic bank);
    cmd_t c;
    c = '0;
    c.has_hdr = 1'b1;
    c.pkt_end = 1'b1;
    c.len     = len;
    c.bank    = bank;
    unique case (mode)
      RUN_REPEAT: begin
        c.kind  = CMD_PIXEL;
        c.hdr   = RepeatFlag | ((len - 8'd1) & LenMask);
        c.pixel = prior;
      end
      RUN_ONE: begin
        c.kind  = CMD_PIXEL;
        c.hdr   = 8'd0;
        c.pixel = head;
      end
      RUN_RAW: begin
        c.kind  = CMD_STORE;
        c.hdr   = (len - 8'd1) & LenMask;
        c.pixel = head;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/tga_rle_cmd_fifo.sv
`include "tga_rle_pixel_packet_encoder_top_defines.svh"

module tga_rle_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  tga_rle_pkg::cmd_t push_a,
  input  tga_rle_pkg::cmd_t push_b,
  output logic              space2,
  input  logic              pop,
  output logic              q_valid,
  output tga_rle_pkg::cmd_t q_data
);
  import tga_rle_pkg::*;

  localparam int PW  = $clog2(QueueDepth);
  localparam int CNW = $clog2(QueueDepth + 1);

  cmd_t           slot_r [QueueDepth];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_b;
  logic [CNW-1:0] cnt_r, cnt_nxt;

  assign wr_ptr_b   = wr_ptr_r + PW'(1);
  assign wr_ptr_nxt = wr_ptr_r + PW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign cnt_nxt    = cnt_r + CNW'(push_n) - CNW'(pop);
  assign space2     = cnt_r <= CNW'(QueueDepth - 2);
  assign q_valid    = cnt_r != '0;
  assign q_data     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slot_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      slot_r[wr_ptr_b] <= push_b;
    end
  end

  `TGA_RLE_ASSERT_NEVER(a_fifo_overflow, clk, rst_n, int'(cnt_r) + int'(push_n) > QueueDepth, "command queue overflow")
  `TGA_RLE_ASSERT_NEVER(a_fifo_underflow, clk, rst_n, pop && (cnt_r == '0), "pop from empty command queue")

endmodule

FILE: rtl/core/tga_rle_front.sv
`include "tga_rle_pixel_packet_encoder_top_defines.svh"

module tga_rle_front #(
  parameter int MAX_PACKET = tga_rle_pkg::MaxPacket
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       in_pixel_value,
  input  logic                              in_image_end,
  input  logic [1:0]                        pixel_format,
  input  logic                              rle_enable,
  input  logic                              space2,
  output logic [1:0]                        push_n,
  output tga_rle_pkg::cmd_t                 push_a,
  output tga_rle_pkg::cmd_t                 push_b,
  input  tga_rle_pkg::bank_rel_t            rel,
  output logic                              mem_we,
  output logic [$clog2(MAX_PACKET):0]       mem_waddr,
  output logic [31:0]                       mem_wdata
);
  import tga_rle_pkg::*;

  localparam int AW = $clog2(MAX_PACKET);
  localparam int LW = $clog2(MAX_PACKET + 1);
  localparam logic [LW-1:0] LenMax = LW'(MAX_PACKET);
  localparam logic [LW-1:0] LenOne = LW'(1);
  localparam logic [LW-1:0] LenTwo = LW'(2);

  run_mode_t     mode_r, mode_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [31:0]   prior_r, prior_nxt, head_r, head_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic [31:0]   pix;
  logic          take, we, flip;
  logic [AW-1:0] widx;
  cmd_t          c0, c1;
  logic          v0, v1;

  assign pix      = in_pixel_value & fmt_mask(pixel_format);
  assign in_ready = space2 && !busy_r[bank_r];
  assign take     = in_valid && in_ready;

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    prior_nxt = prior_r;
    head_nxt  = head_r;
    c0 = '0;
    c1 = '0;
    v0 = 1'b0;
    v1 = 1'b0;
    we = 1'b0;
    widx = '0;
    if (!rle_enable) begin
      v0 = mode_r != RUN_EMPTY;
      c0 = flush_cmd(mode_r, 8'(len_r), prior_r, head_r, bank_r);
      v1 = 1'b1;
      c1 = plain_cmd(pix);
      mode_nxt = RUN_EMPTY;
      len_nxt  = '0;
    end else begin
      unique case (mode_r)
        RUN_ONE: begin
          if (pix == prior_r) begin
            mode_nxt = RUN_REPEAT;
          end else begin
            mode_nxt = RUN_RAW;
            we   = 1'b1;
            widx = AW'(1);
          end
          len_nxt   = LenTwo;
          prior_nxt = pix;
        end
        RUN_REPEAT: begin
          if (pix == prior_r) begin
            len_nxt = len_r + LenOne;
          end else begin
            v0 = 1'b1;
            c0 = flush_cmd(mode_r, 8'(len_r), prior_r, head_r, bank_r);
            mode_nxt  = RUN_ONE;
            len_nxt   = LenOne;
            prior_nxt = pix;
            head_nxt  = pix;
          end
        end
        RUN_RAW: begin
          if (pix == prior_r) begin
            v0 = 1'b1;
            c0 = flush_cmd(mode_r, 8'(len_r), prior_r, head_r, bank_r);
            mode_nxt  = RUN_ONE;
            len_nxt   = LenOne;
            prior_nxt = pix;
            head_nxt  = pix;
          end else begin
            we        = 1'b1;
            widx      = len_r[AW-1:0];
            len_nxt   = len_r + LenOne;
            prior_nxt = pix;
          end
        end
        default: begin
          mode_nxt  = RUN_ONE;
          len_nxt   = LenOne;
          prior_nxt = pix;
          head_nxt  = pix;
        end
      endcase
      if (!v0 && mode_nxt != RUN_EMPTY && len_nxt >= LenMax) begin
        v0 = 1'b1;
        c0 = flush_cmd(mode_nxt, 8'(len_nxt), prior_nxt, head_nxt, bank_r);
        mode_nxt = RUN_EMPTY;
        len_nxt  = '0;
      end
      if (in_image_end && mode_nxt != RUN_EMPTY) begin
        v1 = 1'b1;
        c1 = flush_cmd(mode_nxt, 8'(len_nxt), prior_nxt, head_nxt, bank_r);
        mode_nxt = RUN_EMPTY;
        len_nxt  = '0;
      end
    end
    if (v1) begin
      c1.img_end = in_image_end;
    end else begin
      c0.img_end = in_image_end;
    end
  end

  assign flip = (v0 && c0.kind == CMD_STORE) || (v1 && c1.kind == CMD_STORE);

  always_comb begin
    push_n = 2'd0;
    push_a = c0;
    push_b = c1;
    if (take) begin
      if (v0) begin
        push_n = v1 ? 2'd2 : 2'd1;
      end else begin
        push_a = c1;
        push_n = v1 ? 2'd1 : 2'd0;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (take && flip) begin
      busy_nxt[bank_r] = 1'b1;
    end
    bank_nxt = (take && flip) ? ~bank_r : bank_r;
  end

  assign mem_we    = take && we;
  assign mem_waddr = {bank_r, widx};
  assign mem_wdata = pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= RUN_EMPTY;
      len_r   <= '0;
      prior_r <= '0;
      head_r  <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      if (take) begin
        mode_r  <= mode_nxt;
        len_r   <= len_nxt;
        prior_r <= prior_nxt;
        head_r  <= head_nxt;
      end
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

  `TGA_RLE_ASSERT(a_front_bank_free, clk, rst_n, mem_we |-> !busy_r[bank_r], "store write into a draining bank")

endmodule

FILE: rtl/core/tga_rle_back.sv
`include "tga_rle_pixel_packet_encoder_top_defines.svh"

module tga_rle_back #(
  parameter int MAX_PACKET = tga_rle_pkg::MaxPacket
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  tga_rle_pkg::cmd_t           q_data,
  output logic                        pop,
  output tga_rle_pkg::bank_rel_t      rel,
  input  logic                        mem_we,
  input  logic [$clog2(MAX_PACKET):0] mem_waddr,
  input  logic [31:0]                 mem_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_has_header,
  output logic [7:0]                  out_header_byte,
  output logic [2:0]                  out_word_count,
  output logic [31:0]                 out_word_a,
  output logic [31:0]                 out_word_b,
  output logic [31:0]                 out_word_c,
  output logic [31:0]                 out_word_d,
  output logic                        out_packet_done,
  output logic                        out_image_done
);
  import tga_rle_pkg::*;

  localparam int AW = $clog2(MAX_PACKET);
  localparam int LW = $clog2(MAX_PACKET + 1);
  localparam int CW = $clog2(WordsOut);

  logic [31:0] mem [2**(AW+1)];

  back_state_t   state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [2:0]    iss_r, iss_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic          rd_vld_r, rd_vld_nxt, rd_head_r, rd_head_nxt;
  logic [31:0]   rdata_r;
  logic [31:0]   words_r [WordsOut];
  logic [31:0]   words_nxt [WordsOut];

  logic          out_valid_r, out_valid_nxt;
  logic          has_hdr_r, pkt_done_r, img_done_r;
  logic [7:0]    hdr_r;
  logic [2:0]    cnt_r;
  logic [31:0]   ow_r [WordsOut];

  logic [7:0]    rem8, idx8;
  logic [2:0]    gcnt;
  logic          rd_en, last, load, has_hdr_v;
  logic [AW:0]   raddr;
  logic [31:0]   cap_data;

  assign rem8  = cur_r.len - 8'(pos_r);
  assign gcnt  = (cur_r.kind == CMD_PIXEL) ? 3'd1 :
                 ((rem8 >= 8'(WordsOut)) ? 3'(WordsOut) : 3'(rem8));
  assign idx8  = 8'(pos_r) + 8'(iss_r);
  assign raddr = {cur_r.bank, idx8[AW-1:0]};
  assign last  = (cur_r.kind == CMD_PIXEL) || (8'(pos_r) + 8'(gcnt) >= cur_r.len);
  assign cap_data  = rd_head_r ? cur_r.pixel : rdata_r;
  assign has_hdr_v = (cur_r.kind == CMD_STORE) ? (pos_r == '0) : cur_r.has_hdr;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    pos_nxt     = pos_r;
    iss_nxt     = iss_r;
    cap_nxt     = cap_r;
    rd_vld_nxt  = 1'b0;
    rd_head_nxt = 1'b0;
    words_nxt   = words_r;
    rd_en       = 1'b0;
    pop         = 1'b0;
    load        = 1'b0;
    rel         = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          cur_nxt = q_data;
          pos_nxt = '0;
          iss_nxt = '0;
          cap_nxt = '0;
          if (q_data.kind == CMD_PIXEL) begin
            words_nxt[0] = q_data.pixel;
            state_nxt    = BK_OUT;
          end else begin
            state_nxt = BK_FILL;
          end
        end
      end
      BK_FILL: begin
        if (iss_r < gcnt) begin
          rd_en       = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_head_nxt = idx8 == 8'd0;
          iss_nxt     = iss_r + 3'd1;
        end
        if (rd_vld_r) begin
          words_nxt[cap_r] = cap_data;
          cap_nxt          = cap_r + CW'(1);
          if (3'(cap_r) + 3'd1 == gcnt) begin
            state_nxt = BK_OUT;
          end
        end
      end
      BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          load = 1'b1;
          if (last) begin
            rel.valid = cur_r.kind == CMD_STORE;
            rel.bank  = cur_r.bank;
            state_nxt = BK_IDLE;
          end else begin
            pos_nxt   = LW'(8'(pos_r) + 8'(gcnt));
            iss_nxt   = '0;
            cap_nxt   = '0;
            state_nxt = BK_FILL;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pos_r       <= '0;
      iss_r       <= '0;
      cap_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      iss_r       <= iss_nxt;
      cap_r       <= cap_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    rd_head_r <= rd_head_nxt;
    words_r   <= words_nxt;
    if (load) begin
      has_hdr_r  <= has_hdr_v;
      hdr_r      <= has_hdr_v ? cur_r.hdr : 8'd0;
      cnt_r      <= gcnt;
      pkt_done_r <= (cur_r.kind == CMD_STORE) ? last : cur_r.pkt_end;
      img_done_r <= cur_r.img_end && last;
      for (int k = 0; k < WordsOut; k++) begin
        ow_r[k] <= (3'(k) < gcnt) ? words_r[k] : 32'd0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_has_header  = has_hdr_r;
  assign out_header_byte = hdr_r;
  assign out_word_count  = cnt_r;
  assign out_word_a      = ow_r[0];
  assign out_word_b      = ow_r[1];
  assign out_word_c      = ow_r[2];
  assign out_word_d      = ow_r[3];
  assign out_packet_done = pkt_done_r;
  assign out_image_done  = img_done_r;

  `TGA_RLE_ASSERT(a_back_rel_store, clk, rst_n, rel.valid |-> (cur_r.kind == CMD_STORE), "bank released by a pixel command")

endmodule

FILE: rtl/core/tga_rle_pixel_packet_encoder_top.sv
// Channel | Handshake                  | Payload
// in      | in_valid / in_ready        | in_pixel_value, in_image_end
// out     | out_valid / out_ready      | header, word count, four words, done flags
// cfg     | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// Front end takes one pixel per cycle while the command queue has two free slots
// and the literal bank being filled is not still draining.
// Back end: a header or plain pixel result goes straight to the output register;
// raw packets go in groups of up to four, one store read per cycle while filling.
// Reset is synchronous; the literal store is not cleared and needs no sweep.
// Results wait in a queue and a register; an out stall does not halt input at once.
module tga_rle_pixel_packet_encoder_top #(
  parameter int MAX_PACKET = tga_rle_pkg::MaxPacket
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel_value,
  input  logic        in_image_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_has_header,
  output logic [7:0]  out_header_byte,
  output logic [2:0]  out_word_count,
  output logic [31:0] out_word_a,
  output logic [31:0] out_word_b,
  output logic [31:0] out_word_c,
  output logic [31:0] out_word_d,
  output logic        out_packet_done,
  output logic        out_image_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tga_rle_pkg::*;

  localparam int AW = $clog2(MAX_PACKET);

  logic [1:0]  fmt_r;
  logic        rle_r;
  logic        wr_en;

  logic        space2, q_valid, pop;
  logic [1:0]  push_n;
  cmd_t        push_a, push_b, q_data;
  bank_rel_t   rel;
  logic        mem_we;
  logic [AW:0] mem_waddr;
  logic [31:0] mem_wdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_RLE_ENABLE) ? {31'd0, rle_r} : {30'd0, fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_FOUR_BYTE;
      rle_r <= PACKET_MODE;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PIXEL_FORMAT: fmt_r <= pwdata[1:0];
        REG_RLE_ENABLE:   rle_r <= pwdata[0];
        default:          fmt_r <= fmt_r;
      endcase
    end
  end

  tga_rle_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .in_image_end   (in_image_end),
    .pixel_format   (fmt_r),
    .rle_enable     (rle_r),
    .space2         (space2),
    .push_n         (push_n),
    .push_a         (push_a),
    .push_b         (push_b),
    .rel            (rel),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata)
  );

  tga_rle_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (push_n),
    .push_a  (push_a),
    .push_b  (push_b),
    .space2  (space2),
    .pop     (pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  tga_rle_back #(
    .MAX_PACKET(MAX_PACKET)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .rel             (rel),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_has_header  (out_has_header),
    .out_header_byte (out_header_byte),
    .out_word_count  (out_word_count),
    .out_word_a      (out_word_a),
    .out_word_b      (out_word_b),
    .out_word_c      (out_word_c),
    .out_word_d      (out_word_d),
    .out_packet_done (out_packet_done),
    .out_image_done  (out_image_done)
  );

endmodule
